FILE: hw/rtl/sawlf_pkg.sv
// Shared types, codes and constants of the stop-and-wait link framer.
`default_nettype none
package sawlf_pkg;

    // framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // results one input item can cause, at most
    localparam int RUN_MAX   = 12;
    localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

    // configuration register indexes
    localparam int          CFG_IDX_W     = 3;
    localparam logic [2:0]  REG_ADDRESS   = 3'd0;
    localparam logic [2:0]  REG_INFO0     = 3'd1;
    localparam logic [2:0]  REG_INFO1     = 3'd2;
    localparam logic [2:0]  REG_RR0       = 3'd3;
    localparam logic [2:0]  REG_RR1       = 3'd4;
    localparam logic [2:0]  REG_REJ0      = 3'd5;
    localparam logic [2:0]  REG_REJ1      = 3'd6;

    // configuration reset values
    localparam logic [7:0] RST_ADDRESS = 8'd3;
    localparam logic [7:0] RST_INFO0   = 8'd0;
    localparam logic [7:0] RST_INFO1   = 8'd64;
    localparam logic [7:0] RST_RR0     = 8'd5;
    localparam logic [7:0] RST_RR1     = 8'd133;
    localparam logic [7:0] RST_REJ0    = 8'd1;
    localparam logic [7:0] RST_REJ1    = 8'd129;

    // input selector and result kind
    localparam logic FUNC_SEND   = 1'b0;
    localparam logic FUNC_RECV   = 1'b1;
    localparam logic KIND_LINE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // answer status codes
    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;

    typedef enum logic [4:0] {
        P_WAIT  = 5'b00001,
        P_ADDR  = 5'b00010,
        P_CTRL  = 5'b00100,
        P_BCC   = 5'b01000,
        P_CLOSE = 5'b10000
    } t_pstate;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] info0;
        logic [7:0] info1;
        logic [7:0] rr0;
        logic [7:0] rr1;
        logic [7:0] rej0;
        logic [7:0] rej1;
    } t_cfg;

    // all results of one input item
    typedef struct packed {
        logic [RUN_CNT_W-1:0]       cnt;
        logic                       kind;
        logic [1:0]                 status;
        logic                       seq;
        logic [RUN_MAX-1:0][7:0]    bytes;
    } t_run;

endpackage
`default_nettype wire

FILE: hw/rtl/sawlf_cfg.sv
// Configuration register file of the link framer.
`default_nettype none
module sawlf_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sawlf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [7:0]                         i_cfg_data,
    output sawlf_pkg::t_cfg                         o_cfg
);
    import sawlf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address <= RST_ADDRESS;
            r_cfg.info0   <= RST_INFO0;
            r_cfg.info1   <= RST_INFO1;
            r_cfg.rr0     <= RST_RR0;
            r_cfg.rr1     <= RST_RR1;
            r_cfg.rej0    <= RST_REJ0;
            r_cfg.rej1    <= RST_REJ1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ADDRESS: r_cfg.address <= i_cfg_data;
                REG_INFO0:   r_cfg.info0   <= i_cfg_data;
                REG_INFO1:   r_cfg.info1   <= i_cfg_data;
                REG_RR0:     r_cfg.rr0     <= i_cfg_data;
                REG_RR1:     r_cfg.rr1     <= i_cfg_data;
                REG_REJ0:    r_cfg.rej0    <= i_cfg_data;
                REG_REJ1:    r_cfg.rej1    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: hw/rtl/sawlf_proto.sv
// Link protocol state: frame builder with stuffing, answer parser, sequence bit.
`default_nettype none
module sawlf_proto (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sawlf_pkg::t_cfg i_cfg,
    input  wire logic           i_load,
    input  wire logic           i_func,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    output sawlf_pkg::t_run     o_run
);
    import sawlf_pkg::*;

    localparam int NSEG = 7;

    logic       r_seq;
    logic       r_open;
    logic [7:0] r_parity;
    t_pstate    r_pstate;
    logic [7:0] r_ans_addr;
    logic [7:0] r_ans_ctrl;

    t_pstate    n_pstate;
    logic [7:0] n_ans_addr;
    logic [7:0] n_ans_ctrl;
    logic       n_seq;

    logic [7:0]                 ctrl;
    logic [7:0]                 parity_new;
    logic [NSEG-1:0]            seg_en;
    logic [NSEG-1:0]            seg_stuff;
    logic [NSEG-1:0][7:0]       seg_val;
    logic [RUN_MAX-1:0][7:0]    tx_bytes;
    logic [RUN_CNT_W-1:0]       tx_cnt;
    logic                       ans_done;
    logic                       ans_valid;
    logic [1:0]                 ans_status;

    // transmit: header, payload, trailer laid out as segments, stuffed in order
    always_comb begin
        ctrl       = r_seq ? i_cfg.info1 : i_cfg.info0;
        parity_new = (r_open ? r_parity : 8'h00) ^ i_byte;

        seg_val[0] = FLAG_BYTE;
        seg_val[1] = i_cfg.address;
        seg_val[2] = ctrl;
        seg_val[3] = i_cfg.address ^ ctrl;
        seg_val[4] = i_byte;
        seg_val[5] = parity_new;
        seg_val[6] = FLAG_BYTE;
        seg_en     = {i_last, i_last, 1'b1, !r_open, !r_open, !r_open, !r_open};
        seg_stuff  = 7'b0111110;

        tx_bytes = '0;
        tx_cnt   = '0;
        for (int k = 0; k < NSEG; k++) begin
            if (seg_en[k]) begin
                if (seg_stuff[k] && (seg_val[k] == FLAG_BYTE || seg_val[k] == ESC_BYTE)) begin
                    tx_bytes[tx_cnt]         = ESC_BYTE;
                    tx_bytes[tx_cnt + 4'd1]  = (seg_val[k] == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
                    tx_cnt                   = tx_cnt + 4'd2;
                end else begin
                    tx_bytes[tx_cnt] = seg_val[k];
                    tx_cnt           = tx_cnt + 4'd1;
                end
            end
        end
    end

    // receive: supervisory answer parser
    always_comb begin
        n_pstate   = P_WAIT;
        n_ans_addr = r_ans_addr;
        n_ans_ctrl = r_ans_ctrl;
        ans_done   = 1'b0;
        case (r_pstate)
            P_ADDR: begin
                if (i_byte == i_cfg.address) begin
                    n_pstate   = P_CTRL;
                    n_ans_addr = i_byte;
                end else if (i_byte == FLAG_BYTE) begin
                    n_pstate = P_ADDR;
                end
            end
            P_CTRL: begin
                if (i_byte == i_cfg.rr1 || i_byte == i_cfg.rr0 ||
                    i_byte == i_cfg.rej1 || i_byte == i_cfg.rej0) begin
                    n_pstate   = P_BCC;
                    n_ans_ctrl = i_byte;
                end else if (i_byte == FLAG_BYTE) begin
                    n_pstate = P_ADDR;
                end
            end
            P_BCC: begin
                if (i_byte == (r_ans_addr ^ r_ans_ctrl)) begin
                    n_pstate = P_CLOSE;
                end
            end
            P_CLOSE: begin
                ans_done = (i_byte == FLAG_BYTE);
            end
            default: begin
                if (i_byte == FLAG_BYTE) begin
                    n_pstate = P_ADDR;
                end
            end
        endcase

        // control byte is checked against the registers as they are now
        n_seq      = r_seq;
        ans_valid  = 1'b0;
        ans_status = ST_ACCEPTED;
        if (ans_done) begin
            ans_valid = 1'b1;
            if (r_ans_ctrl == i_cfg.rr0) begin
                ans_status = r_seq ? ST_ACCEPTED : ST_DUPLICATE;
                n_seq      = 1'b0;
            end else if (r_ans_ctrl == i_cfg.rr1) begin
                ans_status = r_seq ? ST_DUPLICATE : ST_ACCEPTED;
                n_seq      = 1'b1;
            end else if (r_ans_ctrl == i_cfg.rej0) begin
                ans_status = ST_REJECTED;
                n_seq      = 1'b0;
            end else if (r_ans_ctrl == i_cfg.rej1) begin
                ans_status = ST_REJECTED;
                n_seq      = 1'b1;
            end else begin
                ans_valid = 1'b0;
            end
        end
    end

    always_comb begin
        if (i_func == FUNC_SEND) begin
            o_run.cnt    = tx_cnt;
            o_run.kind   = KIND_LINE;
            o_run.status = ST_ACCEPTED;
            o_run.seq    = r_seq;
            o_run.bytes  = tx_bytes;
        end else begin
            o_run.cnt    = ans_valid ? RUN_CNT_W'(1) : RUN_CNT_W'(0);
            o_run.kind   = KIND_STATUS;
            o_run.status = ans_status;
            o_run.seq    = n_seq;
            o_run.bytes  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= 1'b0;
            r_open     <= 1'b0;
            r_parity   <= 8'h00;
            r_pstate   <= P_WAIT;
            r_ans_addr <= 8'h00;
            r_ans_ctrl <= 8'h00;
        end else if (i_load) begin
            if (i_func == FUNC_SEND) begin
                r_open   <= !i_last;
                r_parity <= i_last ? 8'h00 : parity_new;
            end else begin
                r_pstate   <= n_pstate;
                r_ans_addr <= n_ans_addr;
                r_ans_ctrl <= n_ans_ctrl;
                r_seq      <= n_seq;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sawlf_run.sv
// Result run buffer and output register: drains one result per cycle while the output is not stalled.
`default_nettype none
module sawlf_run (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire sawlf_pkg::t_run i_run,
    output logic                o_free,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output logic [15:0]         o_tdata,   // [7:0] line_byte, [9:8] answer_status,
                                           // [10] sequence_now, [15:11] zero
    output logic                o_tlast,   // last_of_run
    output logic                o_tuser    // result_kind
);
    import sawlf_pkg::*;

    t_run                   r_run;
    logic                   r_run_valid;
    logic [RUN_CNT_W-1:0]   r_idx;
    logic                   r_tvalid;
    logic [15:0]            r_tdata;
    logic                   r_tlast;
    logic                   r_tuser;

    logic out_free;
    logic emit;
    logic run_end;

    assign out_free = !r_tvalid || i_tready;
    assign emit     = r_run_valid && out_free;
    assign run_end  = (r_idx == r_run.cnt - RUN_CNT_W'(1));
    assign o_free   = !r_run_valid || (emit && run_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_idx       <= '0;
            r_tvalid    <= 1'b0;
        end else begin
            if (i_load && i_run.cnt != '0) begin
                r_run_valid <= 1'b1;
                r_idx       <= '0;
            end else if (emit) begin
                r_idx <= r_idx + RUN_CNT_W'(1);
                if (run_end) begin
                    r_run_valid <= 1'b0;
                end
            end
            if (emit) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
        if (emit) begin
            r_tdata <= {5'd0, r_run.seq, r_run.status, r_run.bytes[r_idx]};
            r_tlast <= run_end;
            r_tuser <= r_run.kind;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_run.cnt != '0 && r_idx < r_run.cnt))
        else $error("run index outside its run");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_run.kind == KIND_STATUS) |-> run_end)
        else $error("status report not alone in its run");

    a_load_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_run.cnt != '0) |=> (r_run_valid && r_idx == '0))
        else $error("loaded run not held");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("run loaded over a pending run");

endmodule
`default_nettype wire

FILE: hw/rtl/stop_and_wait_link_framer.sv
// A result reaches the master side through the input register, the run buffer and the output register.
// Throughput, while the master side does not stall: one input item per cycle while each
//   item causes at most one result; otherwise one result per cycle, an item causing up to
//   12 results, set by the single output register draining the run buffer.
// Reset: synchronous, active low; clears configuration to defaults, sequence bit,
//   frame and parser state, and all valid flags.
`default_nettype none
module stop_and_wait_link_framer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sawlf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [7:0]                         i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
    input  wire logic                               s_axis_tlast,  // end_of_frame
    input  wire logic                               s_axis_tuser,  // func
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [15:0]                             m_axis_tdata,  // [7:0] line_byte,
                                                    // [9:8] answer_status,
                                                    // [10] sequence_now, [15:11] zero
    output logic                                    m_axis_tlast,  // last_of_run
    output logic                                    m_axis_tuser   // result_kind
);
    import sawlf_pkg::*;

    t_cfg       cfg;
    t_run       run;
    logic       run_free;
    logic       load;

    logic       r_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    assign load          = r_in_valid && run_free;
    assign s_axis_tready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    sawlf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sawlf_proto u_proto (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_load  (load),
        .i_func  (r_in_func),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_run   (run)
    );

    sawlf_run u_run (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_run    (run),
        .o_free   (run_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
